// ===== design/channel_volume_fade_ramp_assert.svh =====
// Assertion macros for the channel volume fade ramp.
// Used by the top level only; compiled to nothing under SYNTHESIS.
`ifndef CHANNEL_VOLUME_FADE_RAMP_ASSERT_SVH
`define CHANNEL_VOLUME_FADE_RAMP_ASSERT_SVH
`ifndef SYNTHESIS
`define CVFR_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvfr: implication check failed");
`define CVFR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cvfr: next-cycle check failed");
`else
`define CVFR_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define CVFR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/cvfr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the channel volume fade ramp. No dependencies.
package cvfr_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int FRAC_BITS    = 8;

    localparam int MODE_W  = 2;
    localparam int CH_W    = 4;
    localparam int VAL_W   = 8;
    localparam int MASK_W  = 16;
    localparam int DELAY_W = 32;
    localparam int TICK_W  = 16;
    localparam int STEP_W  = 16;

    localparam int IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int AMT_W   = STEP_W + 1;
    localparam int N_W     = AMT_W - FRAC_BITS;
    localparam int DVD_W   = N_W + 2 * FRAC_BITS;
    localparam int DVS_W   = AMT_W;
    localparam int CNT_W   = $clog2(DVD_W);
    localparam int TK100_W = TICK_W + 7;
    localparam int PROD_W  = TK100_W + STEP_W;

    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 3;

    localparam logic [VAL_W-1:0]   DEFAULT_RATE = 8'h88;
    localparam logic [VAL_W-1:0]   DIV_MASK     = 8'h7f;
    localparam int                 DOUBLE_POS   = 7;
    localparam logic [6:0]         TICK_SCALE   = 7'd100;
    localparam logic [TICK_W-1:0]  TICK_RESET   = 16'd1000;
    localparam logic [ADDR_W-3:0]  REG_TICK_PERIOD = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_RATE,
        MODE_SET_VOLUME,
        MODE_START_FADE,
        MODE_UPDATE
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STEP_DIV,
        ST_UPDATE,
        ST_SCALE_DIV,
        ST_MUL,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic {
        DIV_STEP,
        DIV_SCALE
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     decode;
        logic     div_start;
        div_sel_t div_sel;
        logic     step_write;
        logic     update;
        logic     scale_write;
        logic     mul;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic  in_range;
        mode_t mode;
        logic  val_eq_tgt;
        logic  was_idle;
        logic  need_div;
        logic  div_busy;
        logic  div_done;
        logic  out_free;
    } stat_t;

endpackage

// ===== design/cvfr_apb.sv =====
// APB register block: tick_period and its x100 pre-scaled copy.
// Depends on cvfr_pkg.
module cvfr_apb (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cvfr_pkg::ADDR_W-1:0]      paddr,
    input  logic [cvfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cvfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [cvfr_pkg::TK100_W-1:0]     tick100
);
    import cvfr_pkg::*;

    logic [TICK_W-1:0]  tick_period_reg;
    logic [TICK_W-1:0]  tick_period_next;
    logic [TK100_W-1:0] tick100_reg;
    logic [TK100_W-1:0] tick100_next;
    logic               hit;
    logic               wr_en;

    assign hit   = paddr[ADDR_W-1:2] == REG_TICK_PERIOD;
    assign wr_en = psel && penable && pwrite && hit;

    always_comb begin
        tick_period_next = tick_period_reg;
        tick100_next     = tick100_reg;
        if (wr_en) begin
            tick_period_next = pwdata[TICK_W-1:0];
            tick100_next     = TK100_W'(pwdata[TICK_W-1:0]) * TK100_W'(TICK_SCALE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= TICK_RESET;
            tick100_reg     <= TK100_W'(TICK_RESET) * TK100_W'(TICK_SCALE);
        end else begin
            tick_period_reg <= tick_period_next;
            tick100_reg     <= tick100_next;
        end
    end

    assign prdata  = hit ? APB_DATA_W'(tick_period_reg) : '0;
    assign pready  = 1'b1;
    assign tick100 = tick100_reg;

endmodule

// ===== design/cvfr_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Divide by zero yields an all-ones quotient. Depends on cvfr_pkg.
module cvfr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [cvfr_pkg::DVD_W-1:0]  dividend,
    input  logic [cvfr_pkg::DVS_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [cvfr_pkg::DVD_W-1:0]  quotient
);
    import cvfr_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DVD_W-1:0] quot_reg;
    logic [DVD_W-1:0] quot_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] dvs_next;
    logic [DVS_W:0]   rem_sh;
    logic             fits;
    logic             last;

    assign rem_sh = {rem_reg, quot_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};
    assign last   = cnt_reg == CNT_W'(DVD_W - 1);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[DVD_W-2:0], fits};
            rem_next  = fits ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
            cnt_next  = cnt_reg + CNT_W'(1);
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== design/cvfr_dp.sv =====
// Datapath: per-channel fade state, step/scale arithmetic, delay multiply
// and the result register. Depends on cvfr_pkg and cvfr_div.
module cvfr_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cvfr_pkg::cmd_t                  cmd,
    output cvfr_pkg::stat_t                 stat,
    input  logic [cvfr_pkg::MODE_W-1:0]     s_mode,
    input  logic [cvfr_pkg::CH_W-1:0]       s_channel,
    input  logic [cvfr_pkg::VAL_W-1:0]      s_value,
    input  logic [cvfr_pkg::TK100_W-1:0]    tick100,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cvfr_pkg::CH_W-1:0]       m_out_channel,
    output logic [cvfr_pkg::VAL_W-1:0]      m_volume,
    output logic [cvfr_pkg::MASK_W-1:0]     m_active_mask,
    output logic                            m_reschedule,
    output logic [cvfr_pkg::DELAY_W-1:0]    m_delay
);
    import cvfr_pkg::*;

    function automatic logic [STEP_W-1:0] sat16(input logic [DVD_W-1:0] q);
        sat16 = (|q[DVD_W-1:STEP_W]) ? '1 : q[STEP_W-1:0];
    endfunction

    logic [VAL_W-1:0]        cur_reg  [NUM_CHANNELS];
    logic [VAL_W-1:0]        tgt_reg  [NUM_CHANNELS];
    logic [VAL_W-1:0]        rate_reg [NUM_CHANNELS];
    logic [STEP_W-1:0]       step_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] active_reg;
    logic                    m_valid_reg;

    logic [MODE_W-1:0]  mode_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [VAL_W-1:0]   val_reg;
    logic               was_idle_reg;
    logic               again_reg;
    logic [STEP_W-1:0]  scale_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CH_W-1:0]    out_ch_reg;
    logic [VAL_W-1:0]   out_vol_reg;
    logic [MASK_W-1:0]  out_mask_reg;
    logic               out_resched_reg;
    logic [DELAY_W-1:0] out_delay_reg;

    logic [IDX_W-1:0]          idx;
    logic                      in_range;
    logic [VAL_W-1:0]          cur;
    logic [VAL_W-1:0]          tgt;
    logic [VAL_W-1:0]          rate;
    logic [STEP_W-1:0]         step;
    logic [VAL_W-1:0]          rate_eff;
    logic [VAL_W-1:0]          diff_start;
    logic                      up;
    logic [AMT_W-1:0]          amount;
    logic [N_W-1:0]            n;
    logic                      n_zero;
    logic [N_W-1:0]            lim;
    logic [VAL_W-1:0]          gap;
    logic [VAL_W-1:0]          move;
    logic [VAL_W-1:0]          new_cur;
    logic                      need_div;
    logic [DVD_W-1:0]          div_dvd;
    logic [DVS_W-1:0]          div_dvs;
    logic                      div_busy;
    logic                      div_done;
    logic [DVD_W-1:0]          div_q;
    logic [PROD_W+DELAY_W-1:0] prod_sh;
    logic [DELAY_W-1:0]        delay_sat;

    assign idx      = ch_reg[IDX_W-1:0];
    assign in_range = {1'b0, ch_reg} < (CH_W + 1)'(NUM_CHANNELS);
    assign cur      = cur_reg[idx];
    assign tgt      = tgt_reg[idx];
    assign rate     = rate_reg[idx];
    assign step     = step_reg[idx];

    // start fade operands
    assign rate_eff   = (rate == '0) ? DEFAULT_RATE : rate;
    assign diff_start = (val_reg >= cur) ? val_reg - cur : cur - val_reg;

    // update tick
    assign up      = tgt > cur;
    assign amount  = (up && rate[DOUBLE_POS]) ? {step, 1'b0} : {1'b0, step};
    assign n       = amount[AMT_W-1:FRAC_BITS];
    assign n_zero  = n == '0;
    assign lim     = n_zero ? N_W'(1) : n;
    assign gap     = up ? tgt - cur : cur - tgt;
    assign move    = (AMT_W'(gap) > AMT_W'(lim)) ? VAL_W'(lim) : gap;
    assign new_cur = up ? cur + move : cur - move;
    assign need_div = !(n_zero && !up);

    always_comb begin
        if (cmd.div_sel == DIV_STEP) begin
            div_dvd = DVD_W'({diff_start, {FRAC_BITS{1'b0}}});
            div_dvs = DVS_W'(rate_eff & DIV_MASK);
        end else begin
            div_dvd = n_zero ? (DVD_W'(1) << (2 * FRAC_BITS))
                             : (DVD_W'(n) << (2 * FRAC_BITS));
            div_dvs = amount;
        end
    end

    cvfr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign prod_sh   = {{DELAY_W{1'b0}}, prod_reg} >> FRAC_BITS;
    assign delay_sat = (|prod_sh[PROD_W+DELAY_W-1:DELAY_W]) ? '1 : prod_sh[DELAY_W-1:0];

    // channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                cur_reg[i]  <= '0;
                tgt_reg[i]  <= '0;
                rate_reg[i] <= '0;
                step_reg[i] <= '0;
            end
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.decode && in_range) begin
                case (mode_t'(mode_reg))
                    MODE_SET_RATE: begin
                        rate_reg[idx] <= val_reg;
                    end
                    MODE_SET_VOLUME: begin
                        cur_reg[idx]    <= val_reg;
                        tgt_reg[idx]    <= val_reg;
                        active_reg[idx] <= |val_reg;
                    end
                    MODE_START_FADE: begin
                        rate_reg[idx] <= rate_eff;
                        tgt_reg[idx]  <= val_reg;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.step_write) begin
                step_reg[idx] <= sat16(div_q);
            end
            if (cmd.update) begin
                cur_reg[idx]    <= new_cur;
                active_reg[idx] <= |new_cur;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_mode;
            ch_reg   <= s_channel;
            val_reg  <= s_value;
        end
        if (cmd.decode) begin
            was_idle_reg <= tgt == cur;
            again_reg    <= 1'b0;
        end
        if (cmd.update) begin
            again_reg <= new_cur != tgt;
            scale_reg <= amount[STEP_W-1:0];
        end
        if (cmd.scale_write) begin
            scale_reg <= sat16(div_q);
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(tick100) * PROD_W'(scale_reg);
        end
        if (cmd.emit) begin
            out_ch_reg      <= ch_reg;
            out_vol_reg     <= cur;
            out_mask_reg    <= MASK_W'(active_reg);
            out_resched_reg <= again_reg;
            out_delay_reg   <= again_reg ? delay_sat : '0;
        end
    end

    always_comb begin
        stat.in_range   = in_range;
        stat.mode       = mode_t'(mode_reg);
        stat.val_eq_tgt = val_reg == tgt;
        stat.was_idle   = was_idle_reg;
        stat.need_div   = need_div;
        stat.div_busy   = div_busy;
        stat.div_done   = div_done;
        stat.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = out_ch_reg;
    assign m_volume      = out_vol_reg;
    assign m_active_mask = out_mask_reg;
    assign m_reschedule  = out_resched_reg;
    assign m_delay       = out_delay_reg;

endmodule

// ===== design/cvfr_ctrl.sv =====
// Controller state machine: sequences decode, divides, multiply and result.
// Depends on cvfr_pkg.
module cvfr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  cvfr_pkg::stat_t stat,
    output cvfr_pkg::cmd_t  cmd
);
    import cvfr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = ST_IDLE;
                if (stat.in_range) begin
                    case (stat.mode)
                        MODE_SET_RATE: begin
                            state_next = ST_IDLE;
                        end
                        MODE_SET_VOLUME: begin
                            state_next = ST_EMIT;
                        end
                        MODE_START_FADE: begin
                            if (!stat.val_eq_tgt) begin
                                cmd.div_start = 1'b1;
                                cmd.div_sel   = DIV_STEP;
                                state_next    = ST_STEP_DIV;
                            end
                        end
                        default: begin
                            state_next = ST_UPDATE;
                        end
                    endcase
                end
            end
            ST_STEP_DIV: begin
                if (stat.div_done) begin
                    cmd.step_write = 1'b1;
                    state_next     = stat.was_idle ? ST_UPDATE : ST_IDLE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (stat.need_div) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SCALE;
                    state_next    = ST_SCALE_DIV;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_SCALE_DIV: begin
                cmd.div_sel = DIV_SCALE;
                if (stat.div_done) begin
                    cmd.scale_write = 1'b1;
                    state_next      = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/channel_volume_fade_ramp.sv =====
// Channel volume fade ramp, top level: APB registers, controller, datapath.
// One item at a time; s_ready is high only while the controller is idle.
// Set rate: no result. Set volume: result once the output slot is free. Update tick:
// the scale divide unless none is due. Start fade, if value and target differ: the
// step divide, then an update if the channel was idle. The divider has 25 steps.
// Reset (aresetn, synchronous, active low) zeroes channel state, tick_period to 1000.
`include "channel_volume_fade_ramp_assert.svh"
module channel_volume_fade_ramp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [cvfr_pkg::MODE_W-1:0]      s_mode,
    input  logic [cvfr_pkg::CH_W-1:0]        s_channel,
    input  logic [cvfr_pkg::VAL_W-1:0]       s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [cvfr_pkg::CH_W-1:0]        m_out_channel,
    output logic [cvfr_pkg::VAL_W-1:0]       m_volume,
    output logic [cvfr_pkg::MASK_W-1:0]      m_active_mask,
    output logic                             m_reschedule,
    output logic [cvfr_pkg::DELAY_W-1:0]     m_delay,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cvfr_pkg::ADDR_W-1:0]      paddr,
    input  logic [cvfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cvfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import cvfr_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic [TK100_W-1:0] tick100;

    cvfr_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick100 (tick100)
    );

    cvfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cvfr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_mode        (s_mode),
        .s_channel     (s_channel),
        .s_value       (s_value),
        .tick100       (tick100),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_volume      (m_volume),
        .m_active_mask (m_active_mask),
        .m_reschedule  (m_reschedule),
        .m_delay       (m_delay)
    );

    `CVFR_ASSERT_IMPLIES(a_emit_slot_free, aclk, aresetn, cmd.emit, !m_valid || m_ready)
    `CVFR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `CVFR_ASSERT_IMPLIES(a_div_start_idle, aclk, aresetn, cmd.div_start, !stat.div_busy)
    `CVFR_ASSERT_IMPLIES(a_no_delay_when_done, aclk, aresetn, m_valid && !m_reschedule, m_delay == '0)

endmodule
